FILE: rtl/core/atm_pkg.sv
package atm_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_LEN          = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS < ATAN_LEN) ?
                                       CORDIC_ITERATIONS : ATAN_LEN;
    localparam int STEP_W            = $clog2(ATAN_LEN);

    localparam int RAW_W    = 16;
    localparam int AXIS_W   = 12;
    localparam int HSQ_W    = 24;
    localparam int RAD_W    = 40;
    localparam int SQ_W     = 42;
    localparam int ROOT_W   = 21;
    localparam int SQ_STEPS = 21;
    localparam int SQK_W    = 5;
    localparam int ZQ_W     = 20;
    localparam int CV_W     = 24;
    localparam int ACC_W    = 25;
    localparam int ANGLE_W  = 15;

    localparam logic [ANGLE_W-1:0]      NINETY_Q8  = 15'd23040;
    localparam logic signed [ACC_W-1:0] NINETY_Q16 = 25'sd5898240;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_X,
        S_SQ_Y,
        S_CLASS,
        S_ROOT,
        S_ROT,
        S_FIN
    } t_state;

    function automatic logic signed [ACC_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 25'sd2949120;
            5'd1:    v = 25'sd1740967;
            5'd2:    v = 25'sd919879;
            5'd3:    v = 25'sd466945;
            5'd4:    v = 25'sd234379;
            5'd5:    v = 25'sd117304;
            5'd6:    v = 25'sd58666;
            5'd7:    v = 25'sd29335;
            5'd8:    v = 25'sd14668;
            5'd9:    v = 25'sd7334;
            5'd10:   v = 25'sd3667;
            5'd11:   v = 25'sd1833;
            5'd12:   v = 25'sd917;
            5'd13:   v = 25'sd458;
            5'd14:   v = 25'sd229;
            5'd15:   v = 25'sd115;
            5'd16:   v = 25'sd57;
            5'd17:   v = 25'sd29;
            5'd18:   v = 25'sd14;
            5'd19:   v = 25'sd7;
            5'd20:   v = 25'sd4;
            5'd21:   v = 25'sd2;
            5'd22:   v = 25'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/atm_sqrt.sv
module atm_sqrt
    import atm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [RAD_W-1:0]  i_radicand,
    output logic              o_busy,
    output logic [ROOT_W-1:0] o_root
);

    logic              r_busy;
    logic [SQK_W-1:0]  r_k;
    logic [RAD_W-1:0]  r_v;
    logic [SQ_W-1:0]   r_res;

    logic [SQ_W-1:0]   bit_val;
    logic [SQ_W-1:0]   trial;
    logic [SQ_W-1:0]   diff;
    logic              take;

    // one root bit per cycle, restoring
    always_comb begin
        bit_val = SQ_W'(1) << {r_k, 1'b0};
        trial   = r_res + bit_val;
        take    = ({2'b00, r_v} >= trial);
        diff    = {2'b00, r_v} - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_k == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_v   <= i_radicand;
            r_res <= '0;
            r_k   <= SQK_W'(SQ_STEPS - 1);
        end else if (r_busy) begin
            if (take) begin
                r_v   <= diff[RAD_W-1:0];
                r_res <= (r_res >> 1) + bit_val;
            end else begin
                r_res <= r_res >> 1;
            end
            r_k <= r_k - SQK_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[ROOT_W-1:0];

endmodule

FILE: rtl/core/atm_cordic.sv
module atm_cordic
    import atm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [ZQ_W-1:0]    i_zq,
    input  logic [ROOT_W-1:0]  i_r,
    output logic               o_busy,
    output logic [ANGLE_W-1:0] o_angle
);

    logic                     r_busy;
    logic [STEP_W-1:0]        r_i;
    logic signed [CV_W-1:0]   r_x;
    logic signed [CV_W-1:0]   r_y;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [CV_W-1:0]   xs;
    logic signed [CV_W-1:0]   ys;
    logic signed [ACC_W-1:0]  atn;
    logic [ACC_W-2:0]         acc_c;
    logic [ACC_W-1:0]         rnd;
    logic [ANGLE_W:0]         q;

    always_comb begin
        xs  = r_x >>> r_i;
        ys  = r_y >>> r_i;
        atn = atan_q16(r_i);
    end

    // clamp to 0..90 deg, round half up to 8 fraction bits
    always_comb begin
        if (r_acc < 0) begin
            acc_c = '0;
        end else if (r_acc > NINETY_Q16) begin
            acc_c = NINETY_Q16[ACC_W-2:0];
        end else begin
            acc_c = r_acc[ACC_W-2:0];
        end
        rnd = {1'b0, acc_c} + ACC_W'(128);
        q   = rnd[ANGLE_W+8:8];
        if (q > {1'b0, NINETY_Q8}) begin
            o_angle = NINETY_Q8;
        end else begin
            o_angle = q[ANGLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_i == STEP_W'(CORDIC_STEPS - 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= signed'(CV_W'(i_zq));
            r_y   <= signed'(CV_W'(i_r));
            r_acc <= '0;
            r_i   <= '0;
        end else if (r_busy) begin
            if (!r_y[CV_W-1]) begin
                r_x   <= r_x + ys;
                r_y   <= r_y - xs;
                r_acc <= r_acc + atn;
            end else begin
                r_x   <= r_x - ys;
                r_y   <= r_y + xs;
                r_acc <= r_acc - atn;
            end
            r_i <= r_i + STEP_W'(1);
        end
    end

    assign o_busy = r_busy;

endmodule

FILE: rtl/core/accel_tilt_max_tracker_top.sv
// flow: a clear goes straight to S_FIN; a general sample is squared, classified,
//   rooted and rotated; all-zero, zero-z and zero-horizontal samples skip both
// throughput: one sample at a time, paced by the 21-step square root
//   and the 16-step cordic loop, both one step per cycle, and by stalls in S_FIN
// reset: synchronous active low, clears the stored maximum and all handshake state
module accel_tilt_max_tracker_top
    import atm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_cmd,
    input  logic [RAW_W-1:0]   i_x_raw,
    input  logic [RAW_W-1:0]   i_y_raw,
    input  logic [RAW_W-1:0]   i_z_raw,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ANGLE_W-1:0] o_tilt_angle,
    output logic               o_tilt_valid,
    output logic [ANGLE_W-1:0] o_max_tilt,
    output logic               o_new_max
);

    t_state r_state;
    t_state n_state;

    logic                     r_cmd;
    logic signed [AXIS_W-1:0] r_x;
    logic signed [AXIS_W-1:0] r_y;
    logic [AXIS_W-1:0]        r_az;
    logic [HSQ_W-1:0]         r_hsq;
    logic [ANGLE_W-1:0]       r_angle;
    logic                     r_valid;
    logic [ANGLE_W-1:0]       r_max;
    logic                     r_out_valid;
    logic [ANGLE_W-1:0]       r_out_angle;
    logic                     r_out_tvalid;
    logic                     r_out_new;

    logic                     in_fire;
    logic                     fin_fire;
    logic                     sqrt_start;
    logic                     cordic_start;
    logic                     sqrt_busy;
    logic                     cordic_busy;
    logic [ROOT_W-1:0]        root;
    logic [ANGLE_W-1:0]       cordic_angle;

    logic signed [AXIS_W-1:0] z_in;
    logic [AXIS_W:0]          z_abs;
    logic signed [AXIS_W-1:0] mul_op;
    logic signed [HSQ_W-1:0]  sq;
    logic                     raise;

    assign in_fire = i_in_valid && o_in_ready;
    assign z_in    = signed'(i_z_raw[RAW_W-1:RAW_W-AXIS_W]);
    assign z_abs   = z_in[AXIS_W-1] ? (AXIS_W+1)'(-(AXIS_W+1)'(z_in))
                                    : (AXIS_W+1)'(z_in);

    // shared squarer for x then y
    assign mul_op = (r_state == S_SQ_X) ? r_x : r_y;
    assign sq     = mul_op * mul_op;
    assign raise  = r_valid && (r_angle > r_max);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_in_ready   = 1'b0;
        sqrt_start   = 1'b0;
        cordic_start = 1'b0;
        fin_fire     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = i_cmd ? S_FIN : S_SQ_X;
                end
            end
            S_SQ_X: n_state = S_SQ_Y;
            S_SQ_Y: n_state = S_CLASS;
            S_CLASS: begin
                if (r_hsq == '0 || r_az == '0) begin
                    n_state = S_FIN;
                end else begin
                    sqrt_start = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                if (!sqrt_busy) begin
                    cordic_start = 1'b1;
                    n_state      = S_ROT;
                end
            end
            S_ROT: begin
                if (!cordic_busy) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    fin_fire = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd   <= i_cmd;
            r_x     <= signed'(i_x_raw[RAW_W-1:RAW_W-AXIS_W]);
            r_y     <= signed'(i_y_raw[RAW_W-1:RAW_W-AXIS_W]);
            r_az    <= z_abs[AXIS_W-1:0];
            r_angle <= '0;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_SQ_X: r_hsq <= HSQ_W'(sq);
                S_SQ_Y: r_hsq <= r_hsq + HSQ_W'(sq);
                S_CLASS: begin
                    r_valid <= (r_hsq != '0) || (r_az != '0);
                    if (r_az == '0 && r_hsq != '0) begin
                        r_angle <= NINETY_Q8;
                    end
                end
                S_ROT: begin
                    if (!cordic_busy) begin
                        r_angle <= cordic_angle;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (fin_fire) begin
                r_out_valid <= 1'b1;
                if (r_cmd) begin
                    r_max <= '0;
                end else if (raise) begin
                    r_max <= r_angle;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_fire) begin
            r_out_angle  <= r_cmd ? '0 : r_angle;
            r_out_tvalid <= !r_cmd && r_valid;
            r_out_new    <= !r_cmd && raise;
        end
    end

    atm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand ({r_hsq, 16'b0}),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    atm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cordic_start),
        .i_zq    ({r_az, 8'b0}),
        .i_r     (root),
        .o_busy  (cordic_busy),
        .o_angle (cordic_angle)
    );

    assign o_out_valid  = r_out_valid;
    assign o_tilt_angle = r_out_angle;
    assign o_tilt_valid = r_out_tvalid;
    assign o_max_tilt   = r_max;
    assign o_new_max    = r_out_new;

endmodule

FILE: rtl/core/atm_chk.sv
module atm_chk
    import atm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic [ANGLE_W-1:0] o_tilt_angle,
    input logic               o_tilt_valid,
    input logic [ANGLE_W-1:0] o_max_tilt,
    input logic               o_new_max
);

    // stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tilt_angle)
            && $stable(o_max_tilt) && $stable(o_new_max))
        else $error("result beat changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_tilt_angle <= NINETY_Q8 && o_max_tilt <= NINETY_Q8)
        else $error("angle above 90 degrees");

    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_tilt_valid |-> o_tilt_angle == '0 && !o_new_max)
        else $error("invalid beat carries angle or new max");

    a_newmax: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_new_max |-> o_max_tilt == o_tilt_angle && o_tilt_valid)
        else $error("new max does not match angle");

endmodule

bind accel_tilt_max_tracker_top atm_chk u_atm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_tilt_angle (o_tilt_angle),
    .o_tilt_valid (o_tilt_valid),
    .o_max_tilt   (o_max_tilt),
    .o_new_max    (o_new_max)
);

FILE: tb/accel_tilt_max_tracker_checker.sv
`timescale 1ns / 100ps

package atm_tb_pkg;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_tilt_cmd;

endpackage

module accel_tilt_max_tracker_checker
    import atm_pkg::*;
    import atm_tb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_cmd,
    input  logic [RAW_W-1:0]   i_x_raw,
    input  logic [RAW_W-1:0]   i_y_raw,
    input  logic [RAW_W-1:0]   i_z_raw,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [ANGLE_W-1:0] i_tilt_angle,
    input  logic               i_tilt_valid,
    input  logic [ANGLE_W-1:0] i_max_tilt,
    input  logic               i_new_max,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               defined;
        logic [ANGLE_W-1:0] peak;
        logic               raised;
    } t_tilt_result;

    localparam longint RIGHT_ANGLE_Q16 = 64'sd5898240;

    t_tilt_result       tilt_q[$];
    logic [ANGLE_W-1:0] peak_tilt;
    int                 fail_total = 0;

    function automatic longint step_angle(input int k);
        case (k)
            0:       return 2949120;
            1:       return 1740967;
            2:       return 919879;
            3:       return 466945;
            4:       return 234379;
            5:       return 117304;
            6:       return 58666;
            7:       return 29335;
            8:       return 14668;
            9:       return 7334;
            10:      return 3667;
            11:      return 1833;
            12:      return 917;
            13:      return 458;
            14:      return 229;
            15:      return 115;
            16:      return 57;
            17:      return 29;
            18:      return 14;
            19:      return 7;
            20:      return 4;
            21:      return 2;
            22:      return 1;
            default: return 0;
        endcase
    endfunction

    // bit-serial restoring square root, floor
    function automatic longint root_floor(input longint v);
        longint rem;
        longint res;
        longint bitv;
        rem  = v;
        res  = 0;
        bitv = 64'sd1 << 40;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [ANGLE_W-1:0] cordic_tilt(input longint zq, input longint r);
        longint cx;
        longint cy;
        longint acc;
        longint xs;
        longint ys;
        longint q;
        cx  = zq;
        cy  = r;
        acc = 0;
        for (int k = 0; k < CORDIC_STEPS; k++) begin
            xs = cx >>> k;
            ys = cy >>> k;
            if (cy >= 0) begin
                cx  = cx + ys;
                cy  = cy - xs;
                acc = acc + step_angle(k);
            end else begin
                cx  = cx - ys;
                cy  = cy + xs;
                acc = acc - step_angle(k);
            end
        end
        if (acc < 0)
            acc = 0;
        if (acc > RIGHT_ANGLE_Q16)
            acc = RIGHT_ANGLE_Q16;
        q = (acc + 128) >>> 8;
        if (q > longint'(NINETY_Q8))
            q = longint'(NINETY_Q8);
        return q[ANGLE_W-1:0];
    endfunction

    function automatic logic [ANGLE_W-1:0] tilt_for_sample(
        input  logic [RAW_W-1:0] xr,
        input  logic [RAW_W-1:0] yr,
        input  logic [RAW_W-1:0] zr,
        output logic             defined
    );
        logic signed [AXIS_W-1:0] xa;
        logic signed [AXIS_W-1:0] ya;
        logic signed [AXIS_W-1:0] za;
        longint lx;
        longint ly;
        longint lz;
        longint hsq;
        xa  = xr[RAW_W-1 -: AXIS_W];
        ya  = yr[RAW_W-1 -: AXIS_W];
        za  = zr[RAW_W-1 -: AXIS_W];
        lx  = xa;
        ly  = ya;
        lz  = za;
        if (lz < 0)
            lz = -lz;
        hsq = lx * lx + ly * ly;
        defined = (hsq != 0) || (lz != 0);
        if (!defined)
            return '0;
        if (lz == 0)
            return NINETY_Q8;
        if (hsq == 0)
            return '0;
        return cordic_tilt(lz << 8, root_floor(hsq << 16));
    endfunction

    task automatic report_mismatch(
        input string              what,
        input logic [ANGLE_W-1:0] got,
        input logic [ANGLE_W-1:0] want
    );
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin : watch
        t_tilt_result       got;
        t_tilt_result       want;
        logic               defined;
        logic [ANGLE_W-1:0] angle;
        if (!i_rst_n) begin
            peak_tilt = '0;
            tilt_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = {i_tilt_angle, i_tilt_valid, i_max_tilt, i_new_max};
                if (tilt_q.size() == 0) begin
                    report_mismatch("result beat with nothing pending", got.angle, '0);
                end else begin
                    want = tilt_q.pop_front();
                    if (got.angle !== want.angle)
                        report_mismatch("tilt_angle", got.angle, want.angle);
                    if (got.defined !== want.defined)
                        report_mismatch("tilt_valid", ANGLE_W'(got.defined),
                                        ANGLE_W'(want.defined));
                    if (got.peak !== want.peak)
                        report_mismatch("max_tilt", got.peak, want.peak);
                    if (got.raised !== want.raised)
                        report_mismatch("new_max", ANGLE_W'(got.raised),
                                        ANGLE_W'(want.raised));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = '0;
                if (i_cmd == CMD_CLEAR) begin
                    peak_tilt = '0;
                end else begin
                    angle = tilt_for_sample(i_x_raw, i_y_raw, i_z_raw, defined);
                    want.angle   = angle;
                    want.defined = defined;
                    if (defined && angle > peak_tilt) begin
                        peak_tilt   = angle;
                        want.raised = 1'b1;
                    end
                end
                want.peak = peak_tilt;
                tilt_q.push_back(want);
            end
        end
        o_pending    <= tilt_q.size();
        o_fail_count <= fail_total;
    end

endmodule

FILE: tb/accel_tilt_max_tracker_top_test.sv
`timescale 1ns / 100ps

module accel_tilt_max_tracker_top_test;
    import atm_pkg::*;
    import atm_tb_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_BEATS    = 1850;
    localparam int HOLD_OFF_AFTER  = 40;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int DRAIN_CYCLES    = 64;
    localparam int WATCHDOG_LIMIT  = 4000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_cmd;
    logic [RAW_W-1:0]   i_x_raw;
    logic [RAW_W-1:0]   i_y_raw;
    logic [RAW_W-1:0]   i_z_raw;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [ANGLE_W-1:0] o_tilt_angle;
    logic               o_tilt_valid;
    logic [ANGLE_W-1:0] o_max_tilt;
    logic               o_new_max;

    int          fail_count;
    int          pending_results;
    int unsigned results_seen = 0;
    int unsigned idle_cycles  = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    accel_tilt_max_tracker_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_x_raw      (i_x_raw),
        .i_y_raw      (i_y_raw),
        .i_z_raw      (i_z_raw),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_tilt_angle (o_tilt_angle),
        .o_tilt_valid (o_tilt_valid),
        .o_max_tilt   (o_max_tilt),
        .o_new_max    (o_new_max)
    );

    accel_tilt_max_tracker_checker tilt_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_x_raw      (i_x_raw),
        .i_y_raw      (i_y_raw),
        .i_z_raw      (i_z_raw),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_tilt_angle (o_tilt_angle),
        .i_tilt_valid (o_tilt_valid),
        .i_max_tilt   (o_max_tilt),
        .i_new_max    (o_new_max),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            results_seen <= results_seen + 1;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[accel_tilt_max_tracker_top] ERROR");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(40, 100);
    endfunction

    function automatic logic [RAW_W-1:0] axis_word(input int unsigned kind);
        logic [AXIS_W-1:0] v;
        logic [3:0]        nib;
        nib = 4'($urandom_range(0, 15));
        case (kind)
            0: v = '0;
            1: v = ($urandom_range(0, 1) != 0) ? 12'h800 : 12'h7FF;
            2, 3: begin
                v = AXIS_W'($urandom_range(0, 16));
                v = v - 12'd8;
            end
            default: v = AXIS_W'($urandom);
        endcase
        return {v, nib};
    endfunction

    task automatic send_beat(
        input t_tilt_cmd        op,
        input logic [RAW_W-1:0] xr,
        input logic [RAW_W-1:0] yr,
        input logic [RAW_W-1:0] zr
    );
        int unsigned gap;
        i_in_valid <= 1'b1;
        i_cmd      <= op;
        i_x_raw    <= xr;
        i_y_raw    <= yr;
        i_z_raw    <= zr;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        gap = draw_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // result side: random stalls plus one long hold-off to back up the block
    initial begin : receiver
        int unsigned roll;
        int unsigned span;
        bit          held;
        held = 1'b0;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (!held && results_seen >= HOLD_OFF_AFTER) begin
                held = 1'b1;
                span = HOLD_OFF_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 65) begin
                    i_out_ready <= 1'b1;
                    span = $urandom_range(1, 24);
                end else if (roll < 95) begin
                    i_out_ready <= 1'b0;
                    span = $urandom_range(1, 4);
                end else begin
                    i_out_ready <= 1'b0;
                    span = $urandom_range(20, 90);
                end
            end
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned      mode;
        logic [RAW_W-1:0] xw;
        logic [RAW_W-1:0] yw;
        logic [RAW_W-1:0] zw;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_cmd      <= CMD_SAMPLE;
        i_x_raw    <= '0;
        i_y_raw    <= '0;
        i_z_raw    <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        send_beat(CMD_CLEAR,  16'h1234, 16'h5678, 16'h9ABC);
        send_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_beat(CMD_SAMPLE, 16'h000F, 16'h000A, 16'h0005);
        send_beat(CMD_SAMPLE, 16'h0100, 16'h0000, 16'h0100);
        send_beat(CMD_SAMPLE, 16'h0100, 16'h0000, 16'h0100);
        send_beat(CMD_SAMPLE, 16'h0010, 16'h0000, 16'h0100);
        send_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h0000);
        send_beat(CMD_SAMPLE, 16'h7FF0, 16'h0000, 16'h0000);
        send_beat(CMD_SAMPLE, 16'h0000, 16'h8000, 16'h000F);
        send_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h7FF0);
        send_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 16'h8000);
        send_beat(CMD_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_beat(CMD_SAMPLE, 16'h0000, 16'h0000, 16'hFFFF);
        send_beat(CMD_SAMPLE, 16'h8000, 16'h8000, 16'h8000);
        send_beat(CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_beat(CMD_SAMPLE, 16'hFFF0, 16'h0010, 16'hFFF0);
        send_beat(CMD_SAMPLE, 16'h0010, 16'h0010, 16'h7FF0);
        send_beat(CMD_SAMPLE, 16'h7FF0, 16'h7FF0, 16'h0010);
        send_beat(CMD_SAMPLE, 16'h8000, 16'h7FF0, 16'hFFF0);
        send_beat(CMD_CLEAR,  16'h0000, 16'h0000, 16'h0000);
        send_beat(CMD_SAMPLE, 16'h1230, 16'hABC5, 16'h5A5F);

        // random
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            mode = $urandom_range(0, 99);
            xw   = axis_word($urandom_range(0, 9));
            yw   = axis_word($urandom_range(0, 9));
            zw   = axis_word($urandom_range(0, 9));
            if (mode < 3) begin
                send_beat(CMD_CLEAR, xw, yw, zw);
            end else begin
                if (mode < 8) begin
                    xw = {12'd0, xw[3:0]};
                    yw = {12'd0, yw[3:0]};
                    zw = {12'd0, zw[3:0]};
                end else if (mode < 14) begin
                    zw = {12'd0, zw[3:0]};
                end else if (mode < 20) begin
                    xw = {12'd0, xw[3:0]};
                    yw = {12'd0, yw[3:0]};
                end
                send_beat(CMD_SAMPLE, xw, yw, zw);
            end
        end
        i_in_valid <= 1'b0;

        // let the pending count see the last accepted beat
        @(posedge i_clk);
        while (pending_results != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[accel_tilt_max_tracker_top] OK");
        else
            $display("[accel_tilt_max_tracker_top] ERROR");
        $finish;
    end

endmodule

FILE: accel_tilt_max_tracker_top.f
rtl/core/atm_pkg.sv
rtl/core/atm_sqrt.sv
rtl/core/atm_cordic.sv
rtl/core/accel_tilt_max_tracker_top.sv
rtl/core/atm_chk.sv
tb/accel_tilt_max_tracker_checker.sv
tb/accel_tilt_max_tracker_top_test.sv
